FILE: design/rcc_pkg.sv
// ---------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RGB 3x3 convolution block
// Register indexes, reset values, queue sizing and inter-module structs.
// ---------------------------------------------------------------------------
package rcc_pkg;

	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_COEF_FRAC_BITS = 12;
	localparam int MAX_HEIGHT         = 4096;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP_ROW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID_ROW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM_ROW = 3'd4;

	localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1024;
	localparam logic [47:0] RST_COEF_TOP     = 48'h0;
	localparam logic [47:0] RST_COEF_MID     = 48'h0000_1000_0000;
	localparam logic [47:0] RST_COEF_BOTTOM  = 48'h0;

	localparam int QDEPTH = 4;
	localparam int QCW    = $clog2(QDEPTH + 1);
	localparam int QPW    = $clog2(QDEPTH);

	localparam int PIX_W  = 24;
	localparam int TAP_W  = 16;
	localparam int CHAN_W = 8;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef struct packed {
		logic [10:0] width;
		logic [12:0] height;
	} dim_t;

	typedef struct packed {
		logic [2:0][CFG_DATA_W-1:0] row;
	} coef_t;

	typedef struct packed {
		logic [8:0][PIX_W-1:0] px;
		logic                  last;
	} win_t;

	typedef struct packed {
		logic [QCW-1:0] count;
	} qstat_t;

endpackage

FILE: design/rcc_front.sv
// ---------------------------------------------------------------------------
// rcc_front: input side of the RGB 3x3 convolution
// Tracks position, runs the line buffers and the window, and pushes each
// masked neighborhood that yields an output into the queue.
// ---------------------------------------------------------------------------
module rcc_front #(
	parameter int MAX_WIDTH = rcc_pkg::DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,
	input  logic               s_tuser,
	input  rcc_pkg::dim_t      dim,
	input  rcc_pkg::qstat_t    qstat,
	output logic               q_push,
	output rcc_pkg::win_t      q_data
);

	localparam int IW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int WCW = (WW > 11) ? WW : 11;

	logic [rcc_pkg::PIX_W-1:0] above_mem [MAX_WIDTH];
	logic [rcc_pkg::PIX_W-1:0] cur_mem   [MAX_WIDTH];

	logic [IW-1:0]  in_col_q, out_col_q;
	logic [12:0]    in_row_q, out_row_q;
	logic [WCW-1:0] w_raw, w_eff, in_col_p1, out_col_p1;
	logic [12:0]    h_eff;
	logic [13:0]    out_row_p1;
	logic           accept, produce, in_wrap, out_wrap, last_row, last;
	logic [2:0]     rowok, colok;

	logic                      v_s1, prod_s1, last_s1;
	logic [IW-1:0]             idx_s1;
	logic [rcc_pkg::PIX_W-1:0] pix_s1;
	logic [2:0]                rowok_s1, colok_s1;
	logic [rcc_pkg::PIX_W-1:0] rd_above_q, rd_cur_q, fwd_mid_q, fwd_pix_q;
	logic                      fwd_q;
	logic [rcc_pkg::PIX_W-1:0] top_e, mid_e;
	logic [8:0][rcc_pkg::PIX_W-1:0] win_q, win_n;

	assign w_raw = WCW'(dim.width);
	assign w_eff = (w_raw == '0) ? WCW'(1) :
		(w_raw > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_raw;
	assign h_eff = (dim.height == '0) ? 13'd1 :
		(dim.height > 13'(rcc_pkg::MAX_HEIGHT)) ? 13'(rcc_pkg::MAX_HEIGHT) : dim.height;

	assign q_push   = v_s1 && prod_s1;
	assign s_tready = (rcc_pkg::QCW'(qstat.count) + rcc_pkg::QCW'(q_push))
		< rcc_pkg::QCW'(rcc_pkg::QDEPTH);
	assign accept   = s_tvalid && s_tready;

	assign in_col_p1  = WCW'(in_col_q) + WCW'(1);
	assign out_col_p1 = WCW'(out_col_q) + WCW'(1);
	assign out_row_p1 = {1'b0, out_row_q} + 14'd1;
	assign in_wrap    = in_col_p1 >= w_eff;
	assign out_wrap   = out_col_p1 >= w_eff;
	assign last_row   = out_row_p1 >= {1'b0, h_eff};
	assign produce    = (in_row_q >= 13'd2) || (in_row_q == 13'd1 && in_col_q != '0);
	assign last       = out_wrap && last_row;
	assign rowok      = {!last_row, 1'b1, out_row_q != '0};
	assign colok      = {!out_wrap, 1'b1, out_col_q != '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			v_s1      <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				fwd_q <= v_s1 && (idx_s1 == in_col_q);
				if (produce && last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (in_wrap) begin
						in_col_q <= '0;
						if (in_row_q != '1) begin
							in_row_q <= in_row_q + 13'd1;
						end
					end else begin
						in_col_q <= IW'(in_col_p1);
					end
					if (produce) begin
						if (out_wrap) begin
							out_col_q <= '0;
							out_row_q <= out_row_p1[12:0];
						end else begin
							out_col_q <= IW'(out_col_p1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= in_col_q;
			pix_s1     <= s_tuser ? '0 : s_tdata;
			prod_s1    <= produce;
			last_s1    <= last;
			rowok_s1   <= rowok;
			colok_s1   <= colok;
			rd_above_q <= above_mem[in_col_q];
			rd_cur_q   <= cur_mem[in_col_q];
			fwd_mid_q  <= mid_e;
			fwd_pix_q  <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			above_mem[idx_s1] <= mid_e;
			cur_mem[idx_s1]   <= pix_s1;
		end
	end

	assign top_e = fwd_q ? fwd_mid_q : rd_above_q;
	assign mid_e = fwd_q ? fwd_pix_q : rd_cur_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r*3]   = win_q[r*3+1];
			win_n[r*3+1] = win_q[r*3+2];
		end
		win_n[2] = top_e;
		win_n[5] = mid_e;
		win_n[8] = pix_s1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q_data.px[r*3+c] = (rowok_s1[r] && colok_s1[c]) ? win_n[r*3+c] : '0;
			end
		end
		q_data.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= win_n;
		end
	end

endmodule

FILE: design/rcc_queue.sv
// ---------------------------------------------------------------------------
// rcc_queue: short queue between front and back
// Holds masked neighborhoods so either side can stall on its own.
// ---------------------------------------------------------------------------
module rcc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcc_pkg::win_t   push_data,
	input  logic            pop,
	output rcc_pkg::win_t   pop_data,
	output rcc_pkg::qstat_t qstat
);

	rcc_pkg::win_t              slot_q [rcc_pkg::QDEPTH];
	logic [rcc_pkg::QPW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [rcc_pkg::QCW-1:0]    count_q;

	assign pop_data    = slot_q[rd_ptr_q];
	assign qstat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rcc_pkg::QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rcc_pkg::QPW'(1);
			end
			count_q <= count_q + rcc_pkg::QCW'(push) - rcc_pkg::QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/rcc_back.sv
// ---------------------------------------------------------------------------
// rcc_back: arithmetic side of the RGB 3x3 convolution
// Multiplies the nine taps per channel, sums, floors and clamps to 0..255,
// and holds the result in the output register.
// ---------------------------------------------------------------------------
module rcc_back #(
	parameter int COEF_FRAC_BITS = rcc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rcc_pkg::coef_t  coef,
	input  rcc_pkg::qstat_t qstat,
	input  rcc_pkg::win_t   pop_data,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,
	output logic            m_tlast
);

	localparam int PW = rcc_pkg::CHAN_W + rcc_pkg::TAP_W + 1;
	localparam int SW = PW + 4;

	logic                       v_b1, last_b1, adv_b1, adv_b2;
	logic signed [PW-1:0]       prod_b1 [3][9];
	logic signed [SW-1:0]       sum [3];
	logic signed [SW-1:0]       q [3];
	logic [2:0][rcc_pkg::CHAN_W-1:0] res;

	assign adv_b2 = !m_tvalid || m_tready;
	assign adv_b1 = !v_b1 || adv_b2;
	assign pop    = (qstat.count != '0) && adv_b1;

	always_ff @(posedge clk) begin
		if (pop) begin
			last_b1 <= pop_data.last;
			for (int ch = 0; ch < 3; ch++) begin
				for (int k = 0; k < 9; k++) begin
					prod_b1[ch][k] <= $signed({1'b0,
						pop_data.px[k][ch*rcc_pkg::CHAN_W +: rcc_pkg::CHAN_W]}) *
						$signed(coef.row[k/3][(k%3)*rcc_pkg::TAP_W +: rcc_pkg::TAP_W]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int k = 0; k < 9; k++) begin
				sum[ch] = sum[ch] + SW'(prod_b1[ch][k]);
			end
			q[ch] = sum[ch] >>> COEF_FRAC_BITS;
			if (sum[ch] < 0) begin
				res[ch] = '0;
			end else if (q[ch] > SW'(rcc_pkg::CHAN_MAX)) begin
				res[ch] = rcc_pkg::CHAN_MAX;
			end else begin
				res[ch] = q[ch][rcc_pkg::CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv_b1) begin
				v_b1 <= pop;
			end
			if (adv_b2) begin
				m_tvalid <= v_b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b2 && v_b1) begin
			m_tdata <= res;
			m_tlast <= last_b1;
		end
	end

endmodule

FILE: design/rgb_conv3x3_clamp.sv
// ---------------------------------------------------------------------------
// rgb_conv3x3_clamp: zero-padded 3x3 convolution of an RGB pixel stream
// Line buffers and a window feed a queue; the back end applies Q4.12 taps
// per channel and clamps each result to 0..255.
// ---------------------------------------------------------------------------
// channel   dir  tdata (low bit up)        tuser / tlast
// s_axis    in   red, green, blue          tuser: operation (1 = flush)
// m_axis    out  red, green, blue          tlast: frame_last
// wr        in   wr_data: register value   wr_index: register index
//
// One item is taken per cycle while s_tready is high; m_tvalid rises once the
// item that causes a result has passed the line buffer read, the window into
// the queue, the multiply, then sum and clamp into the output register.
// The line buffers are not cleared after reset; masked taps never use them.
// Output stalls back up through the four-entry queue to s_tready.
// ---------------------------------------------------------------------------
module rgb_conv3x3_clamp #(
	parameter int MAX_WIDTH      = rcc_pkg::DEF_MAX_WIDTH,
	parameter int COEF_FRAC_BITS = rcc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,  // red_in, green_in, blue_in
	input  logic                           s_tuser,  // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,  // red_out, green_out, blue_out
	output logic                           m_tlast,
	input  logic                           wr_en,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0] wr_data
);

	rcc_pkg::dim_t   dim_q;
	rcc_pkg::coef_t  coef_q;
	rcc_pkg::qstat_t qstat;
	rcc_pkg::win_t   push_data, pop_data;
	logic            q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q.width   <= rcc_pkg::RST_IMAGE_WIDTH;
			dim_q.height  <= rcc_pkg::RST_IMAGE_HEIGHT;
			coef_q.row[0] <= rcc_pkg::RST_COEF_TOP;
			coef_q.row[1] <= rcc_pkg::RST_COEF_MID;
			coef_q.row[2] <= rcc_pkg::RST_COEF_BOTTOM;
		end else if (wr_en) begin
			case (wr_index)
				rcc_pkg::REG_IMAGE_WIDTH:     dim_q.width   <= wr_data[10:0];
				rcc_pkg::REG_IMAGE_HEIGHT:    dim_q.height  <= wr_data[12:0];
				rcc_pkg::REG_COEF_TOP_ROW:    coef_q.row[0] <= wr_data;
				rcc_pkg::REG_COEF_MID_ROW:    coef_q.row[1] <= wr_data;
				rcc_pkg::REG_COEF_BOTTOM_ROW: coef_q.row[2] <= wr_data;
				default: begin
				end
			endcase
		end
	end

	rcc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.dim      (dim_q),
		.qstat    (qstat),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	rcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	rcc_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef_q),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |-> (qstat.count < rcc_pkg::QCW'(rcc_pkg::QDEPTH)))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (qstat.count != '0))
		else $error("queue pop while empty");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (qstat.count < rcc_pkg::QCW'(rcc_pkg::QDEPTH)))
		else $error("input ready with a full queue");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for rgb_conv3x3_clamp
// Streams whole RGB frames, each followed by flush items, under many image
// sizes and tap sets. Each output is checked against a line-buffer and window
// model of the zero-padded convolution or, for one-pixel frames, a set value.
// ---------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_out_t;

	typedef struct {
		bit         flush;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         known;
		pixel_out_t want;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [23:0]                    s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [23:0]                    m_tdata;
	logic                           m_tlast;
	logic                           wr_en;
	logic [rcc_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [rcc_pkg::CFG_DATA_W-1:0] wr_data;

	rgb_conv3x3_clamp dut (.*);

	// Model state
	logic [10:0] cfg_width;
	logic [12:0] cfg_height;
	logic [47:0] cfg_coef [3];
	logic [23:0] line_above [rcc_pkg::DEF_MAX_WIDTH];
	logic [23:0] line_cur [rcc_pkg::DEF_MAX_WIDTH];
	logic [23:0] window [9];
	int unsigned in_col, in_row, out_col, out_row;

	pixel_out_t pending_pixels[$];
	int  mismatches;
	int  pixels_checked;
	int  items_sent;
	int  frames_sent;
	bit  bursty;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [7:0] clamp_sum(longint sum);
		longint q;
		if (sum < 0)
			return 8'd0;
		q = sum >>> rcc_pkg::DEF_COEF_FRAC_BITS;
		return (q > 255) ? rcc_pkg::CHAN_MAX : q[7:0];
	endfunction

	function automatic bit conv_predict(bit flush, logic [23:0] pix_in, output pixel_out_t res);
		int unsigned w, h, col;
		logic [23:0] pix, top, mid;
		bit produce, last;
		bit row_ok [3];
		bit col_ok [3];
		longint sum;
		logic signed [15:0] tap;
		logic [7:0] chan [3];
		w = (cfg_width == 0) ? 1 : (cfg_width > rcc_pkg::DEF_MAX_WIDTH) ?
			rcc_pkg::DEF_MAX_WIDTH : cfg_width;
		h = (cfg_height == 0) ? 1 : (cfg_height > rcc_pkg::MAX_HEIGHT) ?
			rcc_pkg::MAX_HEIGHT : cfg_height;
		pix = flush ? 24'd0 : pix_in;
		col = in_col % rcc_pkg::DEF_MAX_WIDTH;
		top = line_above[col];
		mid = line_cur[col];
		line_above[col] = mid;
		line_cur[col] = pix;
		for (int r = 0; r < 3; r++) begin
			window[r*3] = window[r*3+1];
			window[r*3+1] = window[r*3+2];
		end
		window[2] = top;
		window[5] = mid;
		window[8] = pix;
		produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row < 8191)
				in_row++;
		end else
			in_col++;
		if (!produce)
			return 0;
		row_ok[0] = out_row >= 1;
		row_ok[1] = 1;
		row_ok[2] = out_row + 1 < h;
		col_ok[0] = out_col >= 1;
		col_ok[1] = 1;
		col_ok[2] = out_col + 1 < w;
		for (int ch = 0; ch < 3; ch++) begin
			sum = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					if (row_ok[r] && col_ok[c]) begin
						tap = cfg_coef[r][16*c +: 16];
						sum += longint'(window[r*3+c][8*ch +: 8]) * longint'(tap);
					end
			chan[ch] = clamp_sum(sum);
		end
		last = (out_col + 1 >= w) && (out_row + 1 >= h);
		res.red = chan[0];
		res.green = chan[1];
		res.blue = chan[2];
		res.last = last;
		if (last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else
			out_col++;
		return 1;
	endfunction

	task automatic write_reg(logic [rcc_pkg::CFG_IDX_W-1:0] idx, logic [47:0] value);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			rcc_pkg::REG_IMAGE_WIDTH:     cfg_width = value[10:0];
			rcc_pkg::REG_IMAGE_HEIGHT:    cfg_height = value[12:0];
			rcc_pkg::REG_COEF_TOP_ROW:    cfg_coef[0] = value;
			rcc_pkg::REG_COEF_MID_ROW:    cfg_coef[1] = value;
			rcc_pkg::REG_COEF_BOTTOM_ROW: cfg_coef[2] = value;
			default: ;
		endcase
	endtask

	task automatic drain;
		s_tvalid = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(int w, int h, logic [47:0] top, logic [47:0] mid, logic [47:0] bot);
		drain();
		write_reg(rcc_pkg::REG_IMAGE_WIDTH, 48'(w));
		write_reg(rcc_pkg::REG_IMAGE_HEIGHT, 48'(h));
		write_reg(rcc_pkg::REG_COEF_TOP_ROW, top);
		write_reg(rcc_pkg::REG_COEF_MID_ROW, mid);
		write_reg(rcc_pkg::REG_COEF_BOTTOM_ROW, bot);
	endtask

	task automatic send_item(bit flush, logic [7:0] r, logic [7:0] g, logic [7:0] b,
	                         bit known, pixel_out_t want);
		pixel_out_t res;
		if (bursty && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = flush;
		s_tdata = {b, g, r};
		do @(posedge clk); while (!s_tready);
		if (conv_predict(flush, {b, g, r}, res)) begin
			if (known)
				pending_pixels.push_back(want);
			else
				pending_pixels.push_back(res);
		end
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_chan;
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [47:0] rand_coef_row;
		logic [47:0] row;
		for (int c = 0; c < 3; c++)
			case ($urandom_range(0, 5))
				0: row[16*c +: 16] = 16'($urandom_range(0, 65535));
				1: row[16*c +: 16] = 16'd0;
				2: row[16*c +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				default: row[16*c +: 16] = 16'($urandom_range(0, 16'h1400)) - 16'h0A00;
			endcase
		return row;
	endfunction

	task automatic run_frame(int w, int h, bit hold_before_flush);
		pixel_out_t none;
		int ew, eh;
		ew = (w == 0) ? 1 : (w > rcc_pkg::DEF_MAX_WIDTH) ? rcc_pkg::DEF_MAX_WIDTH : w;
		eh = (h == 0) ? 1 : (h > rcc_pkg::MAX_HEIGHT) ? rcc_pkg::MAX_HEIGHT : h;
		none = '{default: 0};
		for (int i = 0; i < ew * eh; i++)
			send_item($urandom_range(0, 29) == 0, rand_chan(), rand_chan(), rand_chan(), 0, none);
		if (hold_before_flush) begin
			s_tvalid = 1'b0;
			while (pending_pixels.size() != 0)
				@(negedge clk);
		end
		for (int i = 0; i <= ew; i++)
			send_item($urandom_range(0, 9) != 0, rand_chan(), rand_chan(), rand_chan(), 0, none);
		frames_sent++;
	endtask

	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output transfer: data %h last %b", m_tdata, m_tlast);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (m_tdata !== {want.blue, want.green, want.red} || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Output mismatch: expected %h last %b, got %h last %b",
						         {want.blue, want.green, want.red}, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	initial begin
		m_tready = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (bursty && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	stim_row_t unit_frames [12] = '{
		'{0, 8'd255, 8'd0,   8'd128, 0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   1, '{8'd255, 8'd0, 8'd128, 1}},
		'{0, 8'd0,   8'd255, 8'd1,   0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   1, '{8'd0, 8'd255, 8'd1, 1}},
		'{0, 8'd7,   8'd9,   8'd11,  0, '{0, 0, 0, 0}},
		'{0, 8'd200, 8'd200, 8'd200, 0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   1, '{8'd7, 8'd9, 8'd11, 1}},
		'{1, 8'd255, 8'd255, 8'd255, 0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   0, '{0, 0, 0, 0}},
		'{1, 8'd0,   8'd0,   8'd0,   1, '{8'd0, 8'd0, 8'd0, 1}}
	};

	initial begin
		int w, h;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		bursty = 1'b0;
		mismatches = 0;
		pixels_checked = 0;
		items_sent = 0;
		frames_sent = 0;
		cfg_width = rcc_pkg::RST_IMAGE_WIDTH;
		cfg_height = rcc_pkg::RST_IMAGE_HEIGHT;
		cfg_coef[0] = rcc_pkg::RST_COEF_TOP;
		cfg_coef[1] = rcc_pkg::RST_COEF_MID;
		cfg_coef[2] = rcc_pkg::RST_COEF_BOTTOM;
		for (int i = 0; i < rcc_pkg::DEF_MAX_WIDTH; i++) begin
			line_above[i] = '0;
			line_cur[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			window[i] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single-pixel frames pass the center tap straight through.
		write_reg(rcc_pkg::REG_IMAGE_WIDTH, 48'd1);
		write_reg(rcc_pkg::REG_IMAGE_HEIGHT, 48'd1);
		foreach (unit_frames[i])
			send_item(unit_frames[i].flush, unit_frames[i].red, unit_frames[i].green,
			          unit_frames[i].blue, unit_frames[i].known, unit_frames[i].want);

		configure(3, 2, 48'h0, 48'h0000_7FFF_0000, 48'h0);
		run_frame(3, 2, 0);
		configure(3, 2, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
		run_frame(3, 2, 0);
		configure(4, 3, 48'hFFFF_FFFF_FFFF, 48'h1000_1000_1000, 48'h0);
		run_frame(4, 3, 0);

		bursty = 1'b1;
		configure(0, 0, rand_coef_row(), rand_coef_row(), rand_coef_row());
		run_frame(0, 0, 0);

		for (int n = 0; n < 880; ) begin
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(13, 40);
				h = $urandom_range(1, 3);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 6);
			end
			if (n > 730)
				bursty = 1'b0;
			configure(w, h, rand_coef_row(), rand_coef_row(), rand_coef_row());
			run_frame(w, h, $urandom_range(0, 5) == 0);
			n += w * h + w + 1;
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Sent %0d items in %0d frames; %0d output pixels checked.",
		         items_sent, frames_sent, pixels_checked);
		$display("Sizes from one pixel up to forty columns, with clamped tap sets.");
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
